/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros shared by the pia design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// expression must never hold
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

/* design/pia_pkg.sv */
// ----------------------------------------------------------------------------
// pia_pkg
// types and constants of the parallel interface adapter
// ----------------------------------------------------------------------------
`default_nettype none

package pia_pkg;

    typedef enum logic [2:0] {
        ACT_BUS_WRITE = 3'd0,
        ACT_BUS_READ  = 3'd1,
        ACT_PIN       = 3'd2,
        ACT_C1        = 3'd3,
        ACT_C2        = 3'd4
    } pia_action_t;

    // control register bits
    localparam int unsigned CTL_C1_IRQ_EN  = 0;
    localparam int unsigned CTL_C1_RISE    = 1;
    localparam int unsigned CTL_DATA_SEL   = 2;
    localparam int unsigned CTL_C2_IRQ_EN  = 3;
    localparam int unsigned CTL_C2_RISE    = 4;
    localparam int unsigned CTL_C2_OUT     = 5;
    localparam int unsigned CTL_C2_FLAG    = 6;
    localparam int unsigned CTL_C1_FLAG    = 7;

    localparam logic [7:0] CTL_FLAGS_MASK = 8'hc0;
    localparam logic [7:0] CTL_WR_MASK    = 8'h3f;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] addr;
        logic [7:0] data;
        logic [7:0] mask;
        logic       port_sel;
    } pia_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       out_valid;
        logic       out_port;
        logic [7:0] out_data;
        logic       irq_a;
        logic       irq_b;
    } pia_resp_t;

    // per-port contribution to one result
    typedef struct packed {
        logic [7:0] read_data;
        logic       out_valid;
        logic [7:0] out_data;
        logic       irq;
    } pia_port_res_t;

endpackage

`default_nettype wire

/* design/pia_port.sv */
// ----------------------------------------------------------------------------
// pia_port
// register file and request logic of one adapter port
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pia_port
    import pia_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          port_id,
    input  wire logic          en,
    input  wire pia_req_t      req,
    output pia_port_res_t      res
);

    logic [7:0] control_reg, control_next;
    logic [7:0] direction_reg, direction_next;
    logic [7:0] latch_reg, latch_next;
    logic [7:0] pin_reg, pin_next;
    logic       c1_reg, c1_next;
    logic       c2_reg, c2_next;
    logic       first_reg, first_next;
    logic       irq_reg, irq_next;

    logic       bus_hit;
    logic       line_hit;
    logic       is_ctrl;
    logic       level;
    logic       edge_c1;
    logic       edge_c2;
    logic [7:0] ctl_tmp;

    assign bus_hit  = (req.addr[1] == port_id);
    assign line_hit = (req.port_sel == port_id);
    assign is_ctrl  = req.addr[0];
    assign level    = |(req.data & req.mask);

    assign edge_c1 = control_reg[CTL_C1_RISE] ? (!c1_reg && level) : (c1_reg && !level);
    assign edge_c2 = control_reg[CTL_C2_RISE] ? (!c2_reg && level) : (c2_reg && !level);

    always_comb
    begin
        control_next   = control_reg;
        direction_next = direction_reg;
        latch_next     = latch_reg;
        pin_next       = pin_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        first_next     = first_reg;
        irq_next       = irq_reg;
        ctl_tmp        = control_reg;
        res.read_data  = 8'h00;
        res.out_valid  = 1'b0;
        res.out_data   = 8'h00;

        unique case (req.action)
            ACT_BUS_WRITE:
            begin
                if (bus_hit) begin
                    if (is_ctrl) begin
                        // c2 as output drops its flag
                        if (req.data[CTL_C2_OUT]) begin
                            ctl_tmp[CTL_C2_FLAG] = 1'b0;
                        end
                        control_next = (ctl_tmp & CTL_FLAGS_MASK) | (req.data & CTL_WR_MASK);
                    end else if (control_reg[CTL_DATA_SEL]) begin
                        if ((latch_reg != req.data) || first_reg) begin
                            latch_next    = req.data;
                            first_next    = 1'b0;
                            res.out_valid = 1'b1;
                            res.out_data  = req.data;
                        end
                    end else begin
                        direction_next = req.data;
                    end
                end
            end
            ACT_BUS_READ:
            begin
                if (bus_hit) begin
                    if (is_ctrl) begin
                        res.read_data = control_reg;
                    end else if (control_reg[CTL_DATA_SEL]) begin
                        irq_next      = 1'b0;
                        control_next  = control_reg & CTL_WR_MASK;
                        res.read_data = (pin_reg & ~direction_reg) | (latch_reg & direction_reg);
                    end else begin
                        res.read_data = direction_reg;
                    end
                end
            end
            ACT_PIN:
            begin
                if (line_hit) begin
                    pin_next = (pin_reg & ~req.mask) | (req.data & req.mask);
                end
            end
            ACT_C1:
            begin
                if (line_hit) begin
                    if (edge_c1) begin
                        irq_next                  = irq_reg | control_reg[CTL_C1_IRQ_EN];
                        control_next[CTL_C1_FLAG] = 1'b1;
                    end
                    c1_next = level;
                end
            end
            ACT_C2:
            begin
                // c2 configured as output ignores the line
                if (line_hit && !control_reg[CTL_C2_OUT]) begin
                    if (edge_c2) begin
                        irq_next                  = irq_reg | control_reg[CTL_C2_IRQ_EN];
                        control_next[CTL_C2_FLAG] = 1'b1;
                    end
                    c2_next = level;
                end
            end
            default:
            begin
            end
        endcase

        res.irq = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            control_reg   <= 8'h00;
            direction_reg <= 8'h00;
            latch_reg     <= 8'h00;
            pin_reg       <= 8'h00;
            c1_reg        <= 1'b0;
            c2_reg        <= 1'b0;
            first_reg     <= 1'b1;
            irq_reg       <= 1'b0;
        end else if (en) begin
            control_reg   <= control_next;
            direction_reg <= direction_next;
            latch_reg     <= latch_next;
            pin_reg       <= pin_next;
            c1_reg        <= c1_next;
            c2_reg        <= c2_next;
            first_reg     <= first_next;
            irq_reg       <= irq_next;
        end
    end

    // interrupt can only be raised by a line event
    `ASSERT_IMPLY(a_irq_rise_src, clk, rst_n, en && !irq_reg && irq_next,
        (req.action == ACT_C1) || (req.action == ACT_C2), "irq raised without line event")
    // an output drive always lands in the latch and clears first-write
    `ASSERT_IMPLY(a_drive_latch, clk, rst_n, $past(en && res.out_valid),
        !first_reg && (latch_reg == $past(req.data)), "driven value not latched")

endmodule

`default_nettype wire

/* design/parallel_interface_adapter.sv */
// ----------------------------------------------------------------------------
// parallel_interface_adapter
// two-port parallel interface adapter with request/response handshake
// ----------------------------------------------------------------------------
// usage:
//   requests (req, req_valid/req_ready) carry a bus write, a bus read, a pin
//   update or a c1/c2 line level. every request yields exactly one response
//   (resp, resp_valid/resp_ready) with read data, an optional new port output
//   value and the interrupt levels of both ports after the request.
//   a response becomes valid once its request has moved from the input
//   register through one pass of port logic into the response register.
//   throughput is one request per cycle unless the receiver stalls; the port
//   registers update in the cycle a request moves into the response register.
//   when the receiver stalls, the response register holds and the input
//   register holds one more request, after which req_ready drops.
//   reset clears both stages and returns every port to its reset state
//   (all registers zero, first-write flag set, interrupts low).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module parallel_interface_adapter
    import pia_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire pia_req_t  req,
    output logic           resp_valid,
    input  wire logic      resp_ready,
    output pia_resp_t      resp
);

    logic          in_valid_reg;
    pia_req_t      in_req_reg;
    logic          resp_valid_reg;
    pia_resp_t     resp_reg;
    pia_resp_t     resp_next;
    logic          advance;
    pia_port_res_t res_a;
    pia_port_res_t res_b;

    assign advance   = in_valid_reg && (!resp_valid_reg || resp_ready);
    assign req_ready = !in_valid_reg || advance;

    pia_port u_port_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .port_id (1'b0),
        .en      (advance),
        .req     (in_req_reg),
        .res     (res_a)
    );

    pia_port u_port_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .port_id (1'b1),
        .en      (advance),
        .req     (in_req_reg),
        .res     (res_b)
    );

    always_comb
    begin
        resp_next.read_data = res_a.read_data | res_b.read_data;
        resp_next.out_valid = res_a.out_valid | res_b.out_valid;
        resp_next.out_port  = res_b.out_valid;
        resp_next.out_data  = res_a.out_data | res_b.out_data;
        resp_next.irq_a     = res_a.irq;
        resp_next.irq_b     = res_b.irq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            resp_valid_reg <= 1'b0;
        end else begin
            if (req_ready) begin
                in_valid_reg <= req_valid;
            end
            if (advance) begin
                resp_valid_reg <= 1'b1;
            end else if (resp_ready) begin
                resp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid) begin
            in_req_reg <= req;
        end
        if (advance) begin
            resp_reg <= resp_next;
        end
    end

    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

    // only one port can drive per request
    `ASSERT_NEVER(a_one_driver, clk, rst_n, advance && res_a.out_valid && res_b.out_valid,
        "both ports drive in one request")
    // read data only on bus reads
    `ASSERT_IMPLY(a_rd_only_read, clk, rst_n,
        advance && (in_req_reg.action != ACT_BUS_READ), resp_next.read_data == 8'h00,
        "read data on non-read request")
    // no request is dropped while the response stage is full
    `ASSERT_IMPLY(a_hold_stall, clk, rst_n, in_valid_reg && resp_valid_reg && !resp_ready,
        !req_ready, "input stage overwritten during stall")

endmodule

`default_nettype wire
